>>> src/btbm_pkg.sv
// Shared types, constants and a helper function for the bitset best-match block.
package btbm_pkg;

	// Default parameter values.
	localparam int BITSET_WORDS_DEF = 64;
	localparam int MAX_REFS_DEF     = 65536;
	localparam int QUEUE_DEPTH_DEF  = 4;

	// Field widths.
	localparam int WORD_W   = 64;
	localparam int BITS_W   = 13;
	localparam int UNION_W  = 14;
	localparam int CHARGE_W = 4;
	localparam int MASS_W   = 32;
	localparam int SCORE_W  = 17;
	localparam int POS_W    = 16;
	localparam int POP_W    = 7;

	// Configuration port.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	// Arithmetic constants.
	localparam int                SHARED_CAP      = 8191;
	localparam int                POS_SPAN        = 65536;
	localparam int                DIV_STEPS       = 16;
	localparam logic [SCORE_W-1:0] Q16_ONE        = 17'h10000;
	localparam logic [MASS_W-1:0]  MASS_WINDOW_RST = 32'd655360;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SCORE_KIND  = 2'd0,
		REG_MASS_WINDOW = 2'd1
	} cfg_reg_t;

	// Score kinds.
	localparam logic KIND_TANIMOTO = 1'b0;
	localparam logic KIND_OVERLAP  = 1'b1;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_FIN
	} back_state_t;

	// A closed reference handed from the front end to the back end.
	typedef struct packed {
		logic [BITS_W-1:0] shared;
		logic [BITS_W-1:0] query_bits;
		logic [BITS_W-1:0] ref_bits;
		logic              eligible;
		logic              last_ref;
	} record_t;

	// One finished result item.
	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [BITS_W-1:0]  shared_bits;
		logic [UNION_W-1:0] union_bits;
		logic               eligible;
		logic               query_done;
		logic [SCORE_W-1:0] best_score;
		logic [POS_W-1:0]   best_index;
	} result_t;

	// Population count of one word.
	function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v);
		logic [POP_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			n = n + POP_W'(v[i]);
		end
		return n;
	endfunction

endpackage

>>> src/btbm_front.sv
// Front end: accumulates the AND popcount and closes each reference into a record.
module btbm_front #(
	parameter int BITSET_WORDS = btbm_pkg::BITSET_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  logic [btbm_pkg::WORD_W-1:0]     query_word,
	input  logic [btbm_pkg::WORD_W-1:0]     ref_word,
	input  logic                            last_word,
	input  logic                            last_ref,
	input  logic [btbm_pkg::BITS_W-1:0]     query_bits,
	input  logic [btbm_pkg::BITS_W-1:0]     ref_bits,
	input  logic [btbm_pkg::CHARGE_W-1:0]   query_charge,
	input  logic [btbm_pkg::CHARGE_W-1:0]   ref_charge,
	input  logic [btbm_pkg::MASS_W-1:0]     query_mass,
	input  logic [btbm_pkg::MASS_W-1:0]     ref_mass,
	input  logic [btbm_pkg::MASS_W-1:0]     mass_window,
	output logic                            rec_push,
	output btbm_pkg::record_t               rec
);
	import btbm_pkg::*;

	// The accumulator saturates at the bitset size or at the field limit.
	localparam int SHARED_LIMIT = (BITSET_WORDS * WORD_W < SHARED_CAP) ?
		BITSET_WORDS * WORD_W : SHARED_CAP;

	logic [BITS_W-1:0]  shared_accum_q;
	logic [BITS_W:0]    shared_raw;
	logic [BITS_W-1:0]  shared_sat;
	logic [MASS_W-1:0]  mass_diff;
	logic               eligible;

	// Add this word pair's overlap and clip at the limit.
	always_comb begin
		shared_raw = {1'b0, shared_accum_q} + (BITS_W+1)'(popcount64(query_word & ref_word));
		if (shared_raw > (BITS_W+1)'(SHARED_LIMIT)) begin
			shared_sat = BITS_W'(SHARED_LIMIT);
		end else begin
			shared_sat = shared_raw[BITS_W-1:0];
		end
	end

	// Charge match and mass window test.
	always_comb begin
		if (query_mass > ref_mass) begin
			mass_diff = query_mass - ref_mass;
		end else begin
			mass_diff = ref_mass - query_mass;
		end
		eligible = (query_charge == ref_charge) && (mass_diff < mass_window);
	end

	// The accumulator restarts after every closed reference.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shared_accum_q <= '0;
		end else if (accept) begin
			shared_accum_q <= last_word ? '0 : shared_sat;
		end
	end

	assign rec_push        = accept && last_word;
	assign rec.shared      = shared_sat;
	assign rec.query_bits  = query_bits;
	assign rec.ref_bits    = ref_bits;
	assign rec.eligible    = eligible;
	assign rec.last_ref    = last_ref;

endmodule

>>> src/btbm_fifo.sv
// Short record queue between the front end and the back end.
module btbm_fifo #(
	parameter int DEPTH = btbm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  btbm_pkg::record_t    wr_data,
	input  logic                 rd_en,
	output btbm_pkg::record_t    rd_data,
	output logic                 full,
	output logic                 empty
);
	import btbm_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	record_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// Storage, written at the tail.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

	// Pointers stay equal whenever the queue is empty.
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers differ while empty");

endmodule

>>> src/btbm_back.sv
// Back end: scores each record with a bit-serial divider and tracks the best match.
module btbm_back #(
	parameter int MAX_REFS = btbm_pkg::MAX_REFS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 score_kind,
	input  logic                 rec_empty,
	input  btbm_pkg::record_t    rec,
	output logic                 rec_pop,
	input  logic                 out_pop,
	output logic                 out_valid,
	output btbm_pkg::result_t    result
);
	import btbm_pkg::*;

	localparam int POS_WRAP = (MAX_REFS < POS_SPAN) ? MAX_REFS : POS_SPAN;
	localparam int STEP_W   = $clog2(DIV_STEPS);

	back_state_t         state_q;
	back_state_t         state_nxt;
	record_t             rec_q;
	logic [UNION_W-1:0]  uni_q;
	logic [UNION_W-1:0]  den_q;
	logic [UNION_W-1:0]  rem_q;
	logic [SCORE_W-1:0]  quo_q;
	logic [STEP_W-1:0]   step_q;
	logic [SCORE_W-1:0]  best_q;
	logic [POS_W-1:0]    best_pos_q;
	logic [POS_W-1:0]    pos_q;
	logic                out_valid_q;
	result_t             result_q;

	logic                load_out;
	logic [UNION_W-1:0]  sum;
	logic                over;
	logic [UNION_W-1:0]  uni;
	logic [UNION_W-1:0]  den;
	logic                zero_case;
	logic                sat_case;
	logic [UNION_W:0]    rem2;
	logic                ge;
	logic                upd;
	logic [SCORE_W-1:0]  best_new;
	logic [POS_W-1:0]    best_pos_new;
	logic [POS_W:0]      pos_inc;

	// Setup of a new record: union, denominator and the degenerate cases.
	always_comb begin
		sum  = UNION_W'(rec.query_bits) + UNION_W'(rec.ref_bits);
		over = UNION_W'(rec.shared) > sum;
		uni  = over ? '0 : sum - UNION_W'(rec.shared);
		if (score_kind == KIND_OVERLAP) begin
			den = (rec.query_bits < rec.ref_bits) ? UNION_W'(rec.query_bits) :
				UNION_W'(rec.ref_bits);
			zero_case = over || (rec.query_bits == '0) || (rec.ref_bits == '0);
		end else begin
			den = uni;
			zero_case = over || ((rec.query_bits == '0) && (rec.ref_bits == '0)) ||
				(uni == '0);
		end
		// A ratio of one or more gives exactly one after clipping.
		sat_case = UNION_W'(rec.shared) >= den;
	end

	// One restoring divide step.
	always_comb begin
		rem2 = {rem_q, 1'b0};
		ge   = rem2 >= {1'b0, den_q};
	end

	// Best-match update and position advance.
	always_comb begin
		upd          = rec_q.eligible && (quo_q > best_q);
		best_new     = upd ? quo_q : best_q;
		best_pos_new = upd ? pos_q : best_pos_q;
		pos_inc      = {1'b0, pos_q} + 1'b1;
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!rec_empty) begin
					state_nxt = (zero_case || sat_case) ? BK_FIN : BK_DIV;
				end
			end
			BK_DIV: begin
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_nxt = BK_FIN;
				end
			end
			BK_FIN: begin
				if (load_out) begin
					state_nxt = BK_IDLE;
				end
			end
			default: state_nxt = BK_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		rec_pop  = (state_q == BK_IDLE) && !rec_empty;
		load_out = (state_q == BK_FIN) && (!out_valid_q || out_pop);
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			best_q      <= '0;
			best_pos_q  <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_pop) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				if (rec_q.last_ref) begin
					best_q     <= '0;
					best_pos_q <= '0;
					pos_q      <= '0;
				end else begin
					best_q     <= best_new;
					best_pos_q <= best_pos_new;
					pos_q      <= (pos_inc >= (POS_W+1)'(POS_WRAP)) ? '0 : pos_inc[POS_W-1:0];
				end
			end
		end
	end

	// Datapath: record capture, divider and result register.
	always_ff @(posedge clk) begin
		if (rec_pop) begin
			rec_q  <= rec;
			uni_q  <= uni;
			den_q  <= den;
			rem_q  <= UNION_W'(rec.shared);
			step_q <= '0;
			if (zero_case) begin
				quo_q <= '0;
			end else if (sat_case) begin
				quo_q <= Q16_ONE;
			end else begin
				quo_q <= '0;
			end
		end else if (state_q == BK_DIV) begin
			rem_q  <= ge ? UNION_W'(rem2 - {1'b0, den_q}) : rem2[UNION_W-1:0];
			quo_q  <= {quo_q[SCORE_W-2:0], ge};
			step_q <= step_q + 1'b1;
		end
		if (load_out) begin
			result_q.score       <= quo_q;
			result_q.shared_bits <= rec_q.shared;
			result_q.union_bits  <= uni_q;
			result_q.eligible    <= rec_q.eligible;
			result_q.query_done  <= rec_q.last_ref;
			result_q.best_score  <= best_new;
			result_q.best_index  <= best_pos_new;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

	// The divider never runs against a zero denominator.
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (den_q != '0))
		else $error("divide step with zero denominator");

	// A delivered score never exceeds one.
	a_score_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.score <= Q16_ONE))
		else $error("score above one");

	// An eligible result never beats the reported best.
	a_best_cover: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.eligible) |-> (result_q.best_score >= result_q.score))
		else $error("best score below an eligible score");

	// The quotient keeps its top bit clear while dividing.
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |=> (quo_q[SCORE_W-1] == 1'b0))
		else $error("divider quotient overflow");

endmodule

>>> src/bitset_tanimoto_best_match_top.sv
// Top level of the bitset similarity search with best-match tracking.
//
// Input channel: one word pair per item, taken when push is high and full is
// low. Words of one reference stream back to back, one item per cycle while
// full is low; the item marked last_word closes the reference and also
// carries the counts, charges, masses and last_ref flag.
// Result channel: one item per closed reference, shown while empty is low
// and taken when pop is high. Results come out in reference order.
// Configuration: cfg_valid/cfg_ready write channel, index 0 score kind,
// index 1 mass window; cfg_ready is always high.
// Each closed reference passes record fetch, 16 divide steps and finish on
// its way to the result ports; degenerate and saturating scores skip the
// divider. Words are taken at one per cycle while full is low; the back end
// takes a new record only after finishing the last one, and a queue of
// QUEUE_DEPTH records absorbs references that arrive faster before full rises.
// A stalled receiver holds the result register; the back end then waits and
// the queue fills, after which full holds off further input.
// Reset clears accumulator, positions, best match, queue and result valid,
// and sets the configuration to Tanimoto with a 10 Da window.
module bitset_tanimoto_best_match_top #(
	parameter int BITSET_WORDS = btbm_pkg::BITSET_WORDS_DEF,
	parameter int MAX_REFS     = btbm_pkg::MAX_REFS_DEF,
	parameter int QUEUE_DEPTH  = btbm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Input channel
	input  logic                              push,
	output logic                              full,
	input  logic [btbm_pkg::WORD_W-1:0]       query_word,
	input  logic [btbm_pkg::WORD_W-1:0]       ref_word,
	input  logic                              last_word,
	input  logic                              last_ref,
	input  logic [btbm_pkg::BITS_W-1:0]       query_bits,
	input  logic [btbm_pkg::BITS_W-1:0]       ref_bits,
	input  logic [btbm_pkg::CHARGE_W-1:0]     query_charge,
	input  logic [btbm_pkg::CHARGE_W-1:0]     ref_charge,
	input  logic [btbm_pkg::MASS_W-1:0]       query_mass,
	input  logic [btbm_pkg::MASS_W-1:0]       ref_mass,
	// Result channel
	output logic                              empty,
	input  logic                              pop,
	output logic [btbm_pkg::SCORE_W-1:0]      score,
	output logic [btbm_pkg::BITS_W-1:0]       shared_bits,
	output logic [btbm_pkg::UNION_W-1:0]      union_bits,
	output logic                              eligible,
	output logic                              query_done,
	output logic [btbm_pkg::SCORE_W-1:0]      best_score,
	output logic [btbm_pkg::POS_W-1:0]        best_index,
	// Configuration channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [btbm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [btbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import btbm_pkg::*;

	logic               score_kind_q;
	logic [MASS_W-1:0]  mass_window_q;
	logic               accept;
	logic               rec_push;
	record_t            rec_in;
	record_t            rec_out;
	logic               rec_pop;
	logic               rec_empty;
	logic               q_full;
	logic               out_valid;
	logic               out_pop;
	result_t            result;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_kind_q  <= KIND_TANIMOTO;
			mass_window_q <= MASS_WINDOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SCORE_KIND:  score_kind_q  <= cfg_data[0];
				REG_MASS_WINDOW: mass_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input handshake.
	assign full   = q_full;
	assign accept = push && !q_full;

	btbm_front #(
		.BITSET_WORDS (BITSET_WORDS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.query_word   (query_word),
		.ref_word     (ref_word),
		.last_word    (last_word),
		.last_ref     (last_ref),
		.query_bits   (query_bits),
		.ref_bits     (ref_bits),
		.query_charge (query_charge),
		.ref_charge   (ref_charge),
		.query_mass   (query_mass),
		.ref_mass     (ref_mass),
		.mass_window  (mass_window_q),
		.rec_push     (rec_push),
		.rec          (rec_in)
	);

	btbm_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_push),
		.wr_data (rec_in),
		.rd_en   (rec_pop),
		.rd_data (rec_out),
		.full    (q_full),
		.empty   (rec_empty)
	);

	btbm_back #(
		.MAX_REFS (MAX_REFS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.score_kind (score_kind_q),
		.rec_empty  (rec_empty),
		.rec        (rec_out),
		.rec_pop    (rec_pop),
		.out_pop    (out_pop),
		.out_valid  (out_valid),
		.result     (result)
	);

	// Result handshake and payload.
	assign empty       = !out_valid;
	assign out_pop     = pop && out_valid;
	assign score       = result.score;
	assign shared_bits = result.shared_bits;
	assign union_bits  = result.union_bits;
	assign eligible    = result.eligible;
	assign query_done  = result.query_done;
	assign best_score  = result.best_score;
	assign best_index  = result.best_index;

endmodule
